// File: design/erpm_pkg.sv
// ----------------------------------------------------------------------------
// erpm_pkg
// Shared types, command codes, register indexes and fixed-point constants of
// the windowed encoder speed estimator.
// ----------------------------------------------------------------------------
package erpm_pkg;

  // Field types
  typedef logic        [1:0]  cmd_t;
  typedef logic signed [20:0] delta_t;
  typedef logic        [19:0] dt_t;
  typedef logic        [15:0] rot_t;
  typedef logic signed [39:0] rpm_t;
  typedef logic        [24:0] ppr_t;
  typedef logic        [16:0] alpha_t;
  typedef logic        [19:0] win_t;
  typedef logic        [3:0]  cfg_idx_t;
  typedef logic        [24:0] cfg_data_t;

  // Command codes
  localparam cmd_t CMD_TICK      = 2'd0;
  localparam cmd_t CMD_BEGIN     = 2'd1;
  localparam cmd_t CMD_CAL_START = 2'd2;
  localparam cmd_t CMD_CAL_END   = 2'd3;

  // Register indexes
  localparam cfg_idx_t REG_STORED_PPR   = 4'd0;
  localparam cfg_idx_t REG_DEFAULT_PPR  = 4'd1;
  localparam cfg_idx_t REG_FILTER_ALPHA = 4'd2;
  localparam cfg_idx_t REG_MIN_WINDOW   = 4'd3;

  // Datapath widths
  localparam int WCNT_W  = 23;  // window counts, signed
  localparam int WUS_W   = 21;  // window microseconds
  localparam int CAL_W   = 32;  // calibration sum, signed
  localparam int NUM_W   = 64;  // divider dividend and quotient
  localparam int DEN_W   = 44;  // divider divisor
  localparam int BLEND_W = 58;  // filter accumulator, signed

  // Constants
  localparam ppr_t   PPR_RESET        = 25'd256000;
  localparam ppr_t   PPR_SANE_MIN     = 25'd128;
  localparam ppr_t   PPR_SANE_MAX     = 25'd25600000;
  localparam alpha_t ALPHA_ONE        = 17'd65536;
  localparam alpha_t ALPHA_RESET      = 17'd13107;
  localparam win_t   MIN_WINDOW_RESET = 20'd10000;
  localparam logic [WUS_W-1:0] STALL_US = 21'd500000;
  // 60e6 us per minute times 2^16 (8 bits of rpm fraction, 8 bits of ppr fraction)
  localparam logic [NUM_W-1:0] NUM_SCALE = 64'd3932160000000;
  localparam logic [BLEND_W-1:0] BLEND_HALF = 58'd32768;

endpackage

// File: design/erpm_intf.sv
// ----------------------------------------------------------------------------
// erpm channel interfaces
// Valid/ready channels for tick items, result items and register writes.
// ----------------------------------------------------------------------------
interface erpm_tick_if import erpm_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  delta_t delta_counts;
  dt_t    dt_us;
  rot_t   rotations;

  modport source (output valid, cmd, delta_counts, dt_us, rotations, input ready);
  modport sink   (input valid, cmd, delta_counts, dt_us, rotations, output ready);
endinterface

interface erpm_result_if import erpm_pkg::*; ();
  logic valid;
  logic ready;
  rpm_t rpm;
  logic rpm_updated;
  logic calibrating;
  logic cal_ok;
  ppr_t effective_ppr;

  modport source (output valid, rpm, rpm_updated, calibrating, cal_ok, effective_ppr,
                  input ready);
  modport sink   (input valid, rpm, rpm_updated, calibrating, cal_ok, effective_ppr,
                  output ready);
endinterface

interface erpm_cfg_if import erpm_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/encoder_windowed_rpm_estimator_top.sv
// ----------------------------------------------------------------------------
// encoder_windowed_rpm_estimator_top
// Windowed encoder speed estimator with first-order IIR smoothing and a
// counts-per-revolution calibration sequence. Serial multiply and divide.
// ----------------------------------------------------------------------------
//  channel  | dir | carries                                         | accepted when
//  tick     | in  | cmd, delta_counts, dt_us, rotations             | valid & ready
//  result   | out | rpm, rpm_updated, calibrating, cal_ok, eff. ppr | valid & ready
//  cfg      | in  | index, data (register write)                    | valid & ready
//
//  One item at a time; tick.ready is high only while the sequencer is idle.
//  Plain items go straight to the output state. A tick that makes an estimate runs
//  23 shift-add steps for numerator and divisor, 64 restoring divide steps
//  and 17 shift-add filter steps. Finish calibration runs the 64 divide steps.
//  A result waiting in the output register holds the sequencer before idle.
//  rst is synchronous; cfg.ready is always high.
// ----------------------------------------------------------------------------
module encoder_windowed_rpm_estimator_top import erpm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  erpm_cfg_if.sink     cfg,
  erpm_tick_if.sink    tick,
  erpm_result_if.source result
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIVLD = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_RAW   = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_CALP  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [5:0] MUL_LAST   = 6'(WCNT_W - 1);
  localparam logic [5:0] DIV_LAST   = 6'(NUM_W - 1);
  localparam logic [5:0] BLEND_LAST = 6'($bits(alpha_t) - 1);

  // configuration registers
  ppr_t   stored_ppr;
  ppr_t   default_ppr;
  alpha_t alpha;
  win_t   min_window;

  // estimator state
  logic signed [WCNT_W-1:0] window_counts;
  logic        [WUS_W-1:0]  window_us;
  rpm_t                     filtered_rpm;
  logic                     cal_mode;
  logic signed [CAL_W-1:0]  cal_total;
  ppr_t                     ppr_in_use;

  // sequencer
  logic [2:0] state;
  logic [5:0] cnt;
  logic       neg;
  logic       op_cal;
  logic       upd_flag;
  logic       ok_flag;

  // serial datapath
  logic [WCNT_W-1:0]  mag_sr;
  logic [WUS_W-1:0]   us_sr;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   mc_num;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   mc_den;
  logic [NUM_W-1:0]   quo;
  logic [DEN_W-1:0]   rem;
  logic [BLEND_W-1:0] acc;
  logic [BLEND_W-1:0] m_raw;
  logic [BLEND_W-1:0] m_flt;
  alpha_t             a_sr;
  alpha_t             b_sr;

  // output register
  logic out_valid;
  rpm_t res_rpm;
  logic res_updated;
  logic res_cal;
  logic res_ok;
  ppr_t res_ppr;

  // combinational helpers
  logic                     accept;
  logic                     can_load;
  logic signed [WCNT_W:0]   wc_sum;
  logic        [WCNT_W-1:0] wc_sat;
  logic        [WCNT_W-1:0] wc_mag;
  logic        [WUS_W-1:0]  us_sum;
  logic        [CAL_W:0]    cal_sum;
  logic        [CAL_W-1:0]  cal_sat;
  logic        [CAL_W-1:0]  cal_mag;
  logic        [NUM_W-1:0]  cal_dividend;
  logic                     stored_sane;
  alpha_t                   alpha_eff;
  logic        [DEN_W:0]    rem_sh;
  logic        [DEN_W+1:0]  div_diff;
  logic                     div_ge;
  logic        [38:0]       q_sat;
  logic        [39:0]       raw_pos;
  logic        [39:0]       raw;
  logic        [BLEND_W-1:0] acc_next;
  ppr_t                     cal_ppr;

  assign accept   = tick.valid && tick.ready;
  assign can_load = !out_valid || result.ready;

  assign tick.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  // window and calibration sums, saturating
  assign wc_sum = {window_counts[WCNT_W-1], window_counts}
                + {{(WCNT_W + 1 - $bits(delta_t)){tick.delta_counts[20]}}, tick.delta_counts};
  always_comb begin
    if (wc_sum[WCNT_W] != wc_sum[WCNT_W-1]) begin
      wc_sat = {wc_sum[WCNT_W], {(WCNT_W - 1){~wc_sum[WCNT_W]}}};
    end else begin
      wc_sat = wc_sum[WCNT_W-1:0];
    end
  end
  assign wc_mag = wc_sat[WCNT_W-1] ? (~wc_sat + 1'b1) : wc_sat;
  assign us_sum = window_us + {1'b0, tick.dt_us};

  assign cal_sum = {cal_total[CAL_W-1], cal_total}
                 + {{(CAL_W + 1 - $bits(delta_t)){tick.delta_counts[20]}}, tick.delta_counts};
  always_comb begin
    if (cal_sum[CAL_W] != cal_sum[CAL_W-1]) begin
      cal_sat = {cal_sum[CAL_W], {(CAL_W - 1){~cal_sum[CAL_W]}}};
    end else begin
      cal_sat = cal_sum[CAL_W-1:0];
    end
  end
  assign cal_mag = cal_sat[CAL_W-1] ? (~cal_sat + 1'b1) : cal_sat;
  // |count| * 256 + rotations / 2
  assign cal_dividend = {24'd0, cal_mag, 8'd0} + {49'd0, tick.rotations[15:1]};

  assign stored_sane = (stored_ppr >= PPR_SANE_MIN) && (stored_ppr <= PPR_SANE_MAX);
  assign alpha_eff   = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

  // one restoring divide step
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b00, den};
  assign div_ge   = !div_diff[DEN_W+1];

  // raw estimate: saturate magnitude, apply sign
  assign q_sat   = (|quo[NUM_W-1:39]) ? '1 : quo[38:0];
  assign raw_pos = {1'b0, q_sat};
  assign raw     = neg ? (~raw_pos + 1'b1) : raw_pos;

  // filter step: alpha*raw + (1-alpha)*filtered, one bit of each weight
  assign acc_next = acc + (a_sr[0] ? m_raw : '0) + (b_sr[0] ? m_flt : '0);

  assign cal_ppr = ((|quo[NUM_W-1:25]) || (quo[24:0] > PPR_SANE_MAX)) ? PPR_SANE_MAX
                                                                      : quo[24:0];

  // configuration registers; a good calibration also rewrites stored_ppr
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_ppr  <= PPR_RESET;
      default_ppr <= PPR_RESET;
      alpha       <= ALPHA_RESET;
      min_window  <= MIN_WINDOW_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          // the calibration result takes precedence in its cycle
          REG_STORED_PPR:   if (state != ST_CALP) stored_ppr <= cfg.data;
          REG_DEFAULT_PPR:  default_ppr <= cfg.data;
          REG_FILTER_ALPHA: alpha       <= cfg.data[16:0];
          REG_MIN_WINDOW:   min_window  <= cfg.data[19:0];
          default: ;
        endcase
      end
      if (state == ST_CALP) stored_ppr <= cal_ppr;
    end
  end

  // sequencer, estimator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      window_counts <= '0;
      window_us     <= '0;
      filtered_rpm  <= '0;
      cal_mode      <= 1'b0;
      cal_total     <= '0;
      ppr_in_use    <= PPR_RESET;
      out_valid     <= 1'b0;
      upd_flag      <= 1'b0;
      ok_flag       <= 1'b0;
      op_cal        <= 1'b0;
    end else begin
      // ST_OUT reloads the register itself when it hands over a new item
      if (out_valid && result.ready && (state != ST_OUT)) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept) begin
            upd_flag <= 1'b0;
            ok_flag  <= 1'b0;
            state    <= ST_OUT;
            case (tick.cmd)
              CMD_TICK: begin
                if (cal_mode) begin
                  cal_total     <= cal_sat;
                  window_counts <= '0;
                  window_us     <= '0;
                end else if (tick.dt_us == '0) begin
                  window_counts <= '0;
                  window_us     <= '0;
                end else if (us_sum > STALL_US) begin
                  // stall: drop the window, keep the speed
                  window_counts <= '0;
                  window_us     <= '0;
                end else if (us_sum >= {1'b0, min_window}) begin
                  window_counts <= '0;
                  window_us     <= '0;
                  if (ppr_in_use != '0) begin
                    mag_sr <= wc_mag;
                    neg    <= wc_sat[WCNT_W-1];
                    us_sr  <= us_sum;
                    num    <= '0;
                    mc_num <= NUM_SCALE;
                    den    <= '0;
                    mc_den <= {{(DEN_W - $bits(ppr_t)){1'b0}}, ppr_in_use};
                    cnt    <= '0;
                    op_cal <= 1'b0;
                    state  <= ST_MUL;
                  end
                end else begin
                  window_counts <= wc_sat;
                  window_us     <= us_sum;
                end
              end
              CMD_BEGIN: begin
                ppr_in_use    <= stored_sane ? stored_ppr : default_ppr;
                filtered_rpm  <= '0;
                cal_mode      <= 1'b0;
                cal_total     <= '0;
                window_counts <= '0;
                window_us     <= '0;
              end
              CMD_CAL_START: begin
                filtered_rpm  <= '0;
                cal_mode      <= 1'b1;
                cal_total     <= '0;
                window_counts <= '0;
                window_us     <= '0;
              end
              CMD_CAL_END: begin
                cal_mode <= 1'b0;
                if ((tick.rotations != '0) && (cal_sat != '0)) begin
                  filtered_rpm  <= '0;
                  cal_total     <= '0;
                  window_counts <= '0;
                  window_us     <= '0;
                  ok_flag       <= 1'b1;
                  quo           <= cal_dividend;
                  den           <= {{(DEN_W - $bits(rot_t)){1'b0}}, tick.rotations};
                  rem           <= '0;
                  cnt           <= '0;
                  op_cal        <= 1'b1;
                  state         <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end

        // numerator = |counts| * scale, divisor = us * ppr, one bit a cycle
        ST_MUL: begin
          if (mag_sr[0]) num <= num + mc_num;
          if (us_sr[0])  den <= den + mc_den;
          mag_sr <= mag_sr >> 1;
          us_sr  <= us_sr >> 1;
          mc_num <= mc_num << 1;
          mc_den <= mc_den << 1;
          cnt    <= cnt + 1'b1;
          if (cnt == MUL_LAST) state <= ST_DIVLD;
        end

        // add half the divisor for round to nearest
        ST_DIVLD: begin
          quo   <= num + {{(NUM_W - DEN_W + 1){1'b0}}, den[DEN_W-1:1]};
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end

        ST_DIV: begin
          rem <= div_ge ? div_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], div_ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= op_cal ? ST_CALP : ST_RAW;
        end

        ST_RAW: begin
          acc   <= BLEND_HALF;
          m_raw <= {{(BLEND_W - 40){raw[39]}}, raw};
          m_flt <= {{(BLEND_W - 40){filtered_rpm[39]}}, filtered_rpm};
          a_sr  <= alpha_eff;
          b_sr  <= ALPHA_ONE - alpha_eff;
          cnt   <= '0;
          state <= ST_BLEND;
        end

        ST_BLEND: begin
          acc   <= acc_next;
          m_raw <= m_raw << 1;
          m_flt <= m_flt << 1;
          a_sr  <= a_sr >> 1;
          b_sr  <= b_sr >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == BLEND_LAST) begin
            // floor divide by 2^16; result always fits 40 bits
            filtered_rpm <= acc_next[55:16];
            upd_flag     <= 1'b1;
            state        <= ST_OUT;
          end
        end

        ST_CALP: begin
          ppr_in_use <= cal_ppr;
          state      <= ST_OUT;
        end

        ST_OUT: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            res_rpm     <= filtered_rpm;
            res_updated <= upd_flag;
            res_cal     <= cal_mode;
            res_ok      <= ok_flag;
            res_ppr     <= ppr_in_use;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.rpm           = res_rpm;
  assign result.rpm_updated   = res_updated;
  assign result.calibrating   = res_cal;
  assign result.cal_ok        = res_ok;
  assign result.effective_ppr = res_ppr;

endmodule

// File: design/erpm_checker.sv
// ----------------------------------------------------------------------------
// erpm_checker
// Port-level checks of the speed estimator, bound to the top level.
// ----------------------------------------------------------------------------
module erpm_checker import erpm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic res_valid,
  input logic res_ready,
  input rpm_t res_rpm,
  input logic res_updated,
  input logic res_cal,
  input logic res_ok,
  input ppr_t res_ppr
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_rpm) && $stable(res_updated)
      && $stable(res_cal) && $stable(res_ok) && $stable(res_ppr))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick ready right after an accepted item");

  // a good calibration leaves calibration mode and clears the speed
  a_cal_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ok |-> !res_cal && (res_rpm == '0) && !res_updated)
    else $error("cal_ok with stale speed or mode");

  // estimates only come from ticks outside calibration
  a_updated: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_updated |-> !res_cal)
    else $error("estimate while calibrating");

endmodule

bind encoder_windowed_rpm_estimator_top erpm_checker u_erpm_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_rpm     (result.rpm),
  .res_updated (result.rpm_updated),
  .res_cal     (result.calibrating),
  .res_ok      (result.cal_ok),
  .res_ppr     (result.effective_ppr)
);
